/* hdl/drc_pkg.sv */
// shared types and constants for the dirty rectangle coalescer
// no dependencies; used by drc_box_unit and dirty_rectangle_coalescer
package drc_pkg;

    localparam int MAX_RECTS_DEF = 8;
    localparam int COORD_W       = 12;
    localparam int MERGE_GAP     = 8;

    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST   = 12'd512;
    localparam logic [COORD_W-1:0] VISIBLE_HEIGHT_RST = 12'd342;

    // configuration register indexes
    localparam logic [1:0] REG_SCREEN_WIDTH   = 2'd0;
    localparam logic [1:0] REG_VISIBLE_HEIGHT = 2'd1;

    // request codes
    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_DRAIN = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // x in the lowest bits, h in the highest
    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_box;

    typedef struct packed {
        logic near;
        t_box uni;
    } t_box_res;

endpackage

/* hdl/drc_box_unit.sv */
// shared compare and union unit: proximity test of a candidate box against
// one stored box and their bounding-box union; depends on drc_pkg
module drc_box_unit (
    input  drc_pkg::t_box     i_cand,
    input  drc_pkg::t_box     i_ent,
    output drc_pkg::t_box_res o_res
);

    localparam int SW = drc_pkg::COORD_W + 2;

    logic [SW-1:0] c_x, c_y, c_x1, c_y1;
    logic [SW-1:0] e_x, e_y, e_x1, e_y1;
    logic [SW-1:0] gap;
    logic [SW-1:0] u_x0, u_y0, u_x1, u_y1, u_w, u_h;

    always_comb begin
        gap  = SW'(drc_pkg::MERGE_GAP);
        c_x  = SW'(i_cand.x);
        c_y  = SW'(i_cand.y);
        c_x1 = SW'(i_cand.x) + SW'(i_cand.w);
        c_y1 = SW'(i_cand.y) + SW'(i_cand.h);
        e_x  = SW'(i_ent.x);
        e_y  = SW'(i_ent.y);
        e_x1 = SW'(i_ent.x) + SW'(i_ent.w);
        e_y1 = SW'(i_ent.y) + SW'(i_ent.h);

        // overlap or within the merge gap on both axes
        o_res.near = (c_x < e_x1 + gap) && (e_x < c_x1 + gap) &&
                     (c_y < e_y1 + gap) && (e_y < c_y1 + gap);

        u_x0 = (c_x < e_x) ? c_x : e_x;
        u_y0 = (c_y < e_y) ? c_y : e_y;
        u_x1 = (c_x1 > e_x1) ? c_x1 : e_x1;
        u_y1 = (c_y1 > e_y1) ? c_y1 : e_y1;
        u_w  = u_x1 - u_x0;
        u_h  = u_y1 - u_y0;

        o_res.uni.x = u_x0[drc_pkg::COORD_W-1:0];
        o_res.uni.y = u_y0[drc_pkg::COORD_W-1:0];
        o_res.uni.w = u_w[drc_pkg::COORD_W-1:0];
        o_res.uni.h = u_h[drc_pkg::COORD_W-1:0];
    end

endmodule

/* hdl/dirty_rectangle_coalescer.sv */
// Dirty rectangle coalescer. One request is taken at a time; ready is low
// while it is worked on. An add is first clipped in the clip state and then
// walks the stored entries in order through the shared compare/union unit,
// stopping at the first entry less than 8 pixels away; a dropped box or an
// empty list finishes in the clip state, with no hit it appends, or on a full
// list it unites into entry 0 in a separate full state. A drain emits one
// rectangle per cycle from the entry store through the output register,
// slowed only by the master side, and a clear or unused code returns at once.
// The last drained rectangle may still wait in the output register while the
// next request is taken.
// depends on drc_pkg and drc_box_unit
module dirty_rectangle_coalescer #(
    parameter int MAX_RECTS = drc_pkg::MAX_RECTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // rect_x, rect_y, rect_w, rect_h
    input  logic [1:0]  s_axis_tuser,  // req_type
    // drained rectangle stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_x, out_y, out_w, out_h
    output logic        m_axis_tlast   // last
);

    localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLIP,
        S_SCAN,
        S_FULL,
        S_DRAIN
    } t_state;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [IW-1:0]                r_idx, n_idx;
    logic [drc_pkg::COORD_W-1:0]  r_screen_width, r_visible_height;
    logic signed [15:0]           r_rx, r_ry, r_rw, r_rh;
    drc_pkg::t_box                r_cand, n_cand;
    drc_pkg::t_box                r_rd;
    drc_pkg::t_box                r_obox, n_obox;
    logic                         r_ovalid, n_ovalid;
    logic                         r_olast, n_olast;

    drc_pkg::t_box                r_store [MAX_RECTS];
    logic                         wr_en;
    logic [IW-1:0]                wr_addr;
    drc_pkg::t_box                wr_box;

    drc_pkg::t_box_res            unit_res;

    logic signed [17:0] x0, y0, w0, h0, x1, y1, w1, h1, w2, h2, lim_w, lim_h;
    logic               clip_empty;
    drc_pkg::t_box      clip_box;
    logic               in_xfer;
    logic               idx_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_obox;
    assign m_axis_tlast  = r_olast;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign idx_last      = ((CW'(r_idx) + CW'(1)) == r_count);

    drc_box_unit u_box (
        .i_cand (r_cand),
        .i_ent  (r_rd),
        .o_res  (unit_res)
    );

    // clip the raw rectangle to the screen
    always_comb begin
        x0    = 18'(r_rx);
        y0    = 18'(r_ry);
        w0    = 18'(r_rw);
        h0    = 18'(r_rh);
        lim_w = $signed({6'd0, r_screen_width});
        lim_h = $signed({6'd0, r_visible_height});
        x1    = (x0 < 0) ? 18'sd0 : x0;
        w1    = (x0 < 0) ? w0 + x0 : w0;
        y1    = (y0 < 0) ? 18'sd0 : y0;
        h1    = (y0 < 0) ? h0 + y0 : h0;
        w2    = (x1 + w1 > lim_w) ? lim_w - x1 : w1;
        h2    = (y1 + h1 > lim_h) ? lim_h - y1 : h1;
        clip_empty = (w0 <= 0) || (h0 <= 0) || (w2 <= 0) || (h2 <= 0);
        clip_box.x = x1[drc_pkg::COORD_W-1:0];
        clip_box.y = y1[drc_pkg::COORD_W-1:0];
        clip_box.w = w2[drc_pkg::COORD_W-1:0];
        clip_box.h = h2[drc_pkg::COORD_W-1:0];
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = '0;
        n_cand   = r_cand;
        n_obox   = r_obox;
        n_ovalid = r_ovalid;
        n_olast  = r_olast;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_box   = unit_res.uni;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (s_axis_tuser)
                        drc_pkg::REQ_ADD:   n_state = S_CLIP;
                        drc_pkg::REQ_DRAIN: n_state = (r_count == '0) ? S_IDLE : S_DRAIN;
                        drc_pkg::REQ_CLEAR: n_count = '0;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_CLIP: begin
                n_cand = clip_box;
                if (clip_empty) begin
                    n_state = S_IDLE;
                end else if (r_count == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_box  = clip_box;
                    n_count = CW'(1);
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (unit_res.near) begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    n_state = S_IDLE;
                end else if (idx_last) begin
                    if (r_count < CW'(MAX_RECTS)) begin
                        // no neighbor found: append
                        wr_en   = 1'b1;
                        wr_addr = r_count[IW-1:0];
                        wr_box  = r_cand;
                        n_count = r_count + CW'(1);
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_FULL;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_FULL: begin
                // list full: fold into entry 0
                wr_en   = 1'b1;
                wr_addr = '0;
                n_state = S_IDLE;
            end
            S_DRAIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_obox   = r_rd;
                    n_olast  = idx_last;
                    if (idx_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else begin
                    n_idx = r_idx;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_count          <= '0;
            r_idx            <= '0;
            r_ovalid         <= 1'b0;
            r_screen_width   <= drc_pkg::SCREEN_WIDTH_RST;
            r_visible_height <= drc_pkg::VISIBLE_HEIGHT_RST;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    drc_pkg::REG_SCREEN_WIDTH:   r_screen_width   <= i_cfg_data;
                    drc_pkg::REG_VISIBLE_HEIGHT: r_visible_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_cand  <= n_cand;
        r_obox  <= n_obox;
        r_olast <= n_olast;
        if (in_xfer) begin
            r_rx <= s_axis_tdata[15:0];
            r_ry <= s_axis_tdata[31:16];
            r_rw <= s_axis_tdata[47:32];
            r_rh <= s_axis_tdata[63:48];
        end
    end

    // entry store, read one address ahead of the sequencer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_box;
        end
        r_rd <= r_store[n_idx];
    end

endmodule

/* dv/tb_dirty_rectangle_coalescer.sv */
// testbench for the dirty rectangle coalescer: directed and random request streams
// checked against a scoreboard that tracks the rectangle list and clip registers
// depends on drc_pkg and the dirty_rectangle_coalescer rtl
module tb_dirty_rectangle_coalescer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = drc_pkg::MAX_RECTS_DEF;
    localparam int SETTLE_CYC  = NUM_SLOTS + 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEM_TARGET = 370;

    // request code with no meaning, ignored by the block
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        int x;
        int y;
        int w;
        int h;
    } t_sb_box;

    typedef struct {
        drc_pkg::t_box b;
        logic          last;
    } t_drained;

    class rect_scoreboard;
        t_sb_box       boxes[NUM_SLOTS];
        int            box_count;
        int            scr_w;
        int            vis_h;
        t_drained      pending[$];
        int            errors;

        function new();
            box_count = 0;
            scr_w     = int'(drc_pkg::SCREEN_WIDTH_RST);
            vis_h     = int'(drc_pkg::VISIBLE_HEIGHT_RST);
            errors    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [11:0] val);
            if (idx == drc_pkg::REG_SCREEN_WIDTH)
                scr_w = int'(val);
            else if (idx == drc_pkg::REG_VISIBLE_HEIGHT)
                vis_h = int'(val);
        endfunction

        function void unite(int idx, t_sb_box c);
            int x0;
            int y0;
            int x1;
            int y1;
            t_sb_box d;
            d  = boxes[idx];
            x0 = (c.x < d.x) ? c.x : d.x;
            y0 = (c.y < d.y) ? c.y : d.y;
            x1 = (c.x + c.w > d.x + d.w) ? c.x + c.w : d.x + d.w;
            y1 = (c.y + c.h > d.y + d.h) ? c.y + c.h : d.y + d.h;
            boxes[idx] = '{x0, y0, x1 - x0, y1 - y0};
        endfunction

        function void note_request(logic [1:0] req, logic [63:0] data);
            t_sb_box       c;
            bit            done;
            t_drained      e;
            c.x = $signed(data[15:0]);
            c.y = $signed(data[31:16]);
            c.w = $signed(data[47:32]);
            c.h = $signed(data[63:48]);
            case (req)
                drc_pkg::REQ_ADD: begin
                    done = (c.w <= 0 || c.h <= 0);
                    if (!done) begin
                        if (c.x < 0) begin
                            c.w += c.x;
                            c.x = 0;
                        end
                        if (c.y < 0) begin
                            c.h += c.y;
                            c.y = 0;
                        end
                        if (c.x + c.w > scr_w) c.w = scr_w - c.x;
                        if (c.y + c.h > vis_h) c.h = vis_h - c.y;
                        done = (c.w <= 0 || c.h <= 0);
                    end
                    // first entry that overlaps or lies within the merge gap wins
                    for (int i = 0; i < box_count && !done; i++) begin
                        if (c.x < boxes[i].x + boxes[i].w + drc_pkg::MERGE_GAP &&
                            boxes[i].x < c.x + c.w + drc_pkg::MERGE_GAP &&
                            c.y < boxes[i].y + boxes[i].h + drc_pkg::MERGE_GAP &&
                            boxes[i].y < c.y + c.h + drc_pkg::MERGE_GAP) begin
                            unite(i, c);
                            done = 1;
                        end
                    end
                    if (!done) begin
                        if (box_count < NUM_SLOTS) begin
                            boxes[box_count] = c;
                            box_count++;
                        end else begin
                            unite(0, c);
                        end
                    end
                end
                drc_pkg::REQ_DRAIN: begin
                    for (int i = 0; i < box_count; i++) begin
                        e.b.x  = boxes[i].x[11:0];
                        e.b.y  = boxes[i].y[11:0];
                        e.b.w  = boxes[i].w[11:0];
                        e.b.h  = boxes[i].h[11:0];
                        e.last = (i + 1 == box_count);
                        pending.push_back(e);
                    end
                    box_count = 0;
                end
                drc_pkg::REQ_CLEAR: box_count = 0;
                default: ;
            endcase
        endfunction

        function void check_rect(logic [47:0] data, logic last);
            drc_pkg::t_box got;
            t_drained      e;
            int            ev[5];
            int            av[5];
            string         fname[5];
            got   = data;
            fname = '{"out_x", "out_y", "out_w", "out_h", "last"};
            if (pending.size() == 0) begin
                $display("%0t: unexpected rectangle, expected none, actual %s",
                         $time, $sformatf("x=%0d y=%0d w=%0d h=%0d last=%0b",
                                          got.x, got.y, got.w, got.h, last));
                errors++;
            end else begin
                e  = pending.pop_front();
                ev = '{e.b.x, e.b.y, e.b.w, e.b.h, e.last};
                av = '{got.x, got.y, got.w, got.h, last};
                for (int i = 0; i < 5; i++) begin
                    if (ev[i] != av[i]) begin
                        $display("%0t: %s mismatch, expected %0d, actual %0d",
                                 $time, fname[i], ev[i], av[i]);
                        errors++;
                    end
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = drc_pkg::REG_SCREEN_WIDTH;
    logic [11:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // rect_x, rect_y, rect_w, rect_h
    logic [1:0]  s_axis_tuser = drc_pkg::REQ_ADD;  // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // out_x, out_y, out_w, out_h
    logic        m_axis_tlast;        // last

    rect_scoreboard sb = new();
    int  cycle_count = 0;
    int  items_sent  = 0;
    int  cur_w = int'(drc_pkg::SCREEN_WIDTH_RST);
    int  cur_h = int'(drc_pkg::VISIBLE_HEIGHT_RST);
    bit  tx_free = 1'b0;
    bit  rx_free = 1'b0;
    int  rx_hold = 0;

    dirty_rectangle_coalescer #(.MAX_RECTS(NUM_SLOTS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short stalls, now and then a long one
    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int tx_gap();
        if (tx_free || $urandom_range(0, 99) < 60) return 0;
        return stall_len();
    endfunction

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (i_rst_n && !rx_free && $urandom_range(0, 4) == 0) begin
            rx_hold = stall_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_rect(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // called at the falling edge right after the previous transfer
    task automatic send_req(logic [1:0] req, int x, int y, int w, int h);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {16'(h), 16'(w), 16'(y), 16'(x)};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic add_rect(int x, int y, int w, int h);
        send_req(drc_pkg::REQ_ADD, x, y, w, h);
    endtask

    task automatic drain_list();
        send_req(drc_pkg::REQ_DRAIN, $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    // adds give no result, so allow the entry walk to finish too
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_regs(logic [11:0] width, logic [11:0] height);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= drc_pkg::REG_SCREEN_WIDTH;
        i_cfg_data  <= width;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= drc_pkg::REG_VISIBLE_HEIGHT;
        i_cfg_data  <= height;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_w = int'(width);
        cur_h = int'(height);
    endtask

    task automatic random_rect(output int x, output int y, output int w, output int h);
        if ($urandom_range(0, 99) < 12) begin
            x = $signed(16'($urandom()));
            y = $signed(16'($urandom()));
            w = $signed(16'($urandom()));
            h = $signed(16'($urandom()));
        end else begin
            x = $urandom_range(0, cur_w + 24) - 12;
            y = $urandom_range(0, cur_h + 24) - 12;
            w = $urandom_range(1, cur_w / 3 + 2);
            h = $urandom_range(1, cur_h / 3 + 2);
            if ($urandom_range(0, 19) == 0) w = -$urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0) h = -$urandom_range(0, 3);
        end
    endtask

    initial begin
        int x;
        int y;
        int w;
        int h;
        int n;
        int r;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at reset clip values
        drain_list();
        add_rect(0, 0, 1, 1);
        add_rect(-10, -5, 30, 20);
        add_rect(32767, 32767, 32767, 32767);
        add_rect(0, 0, 0, 5);
        add_rect(5, 5, 20, -32768);
        add_rect(-32768, 0, 32767, 10);
        add_rect(500, 330, 100, 100);
        add_rect(100, 100, 10, 10);
        add_rect(118, 100, 5, 5);
        send_req(REQ_UNUSED, -1, -1, -1, -1);
        drain_list();
        // nine far apart boxes: the last one folds into entry 0
        for (int i = 0; i < 9; i++) add_rect(i * 48, i * 36, 10, 10);
        drain_list();
        add_rect(20, 20, 30, 30);
        send_req(drc_pkg::REQ_CLEAR, 0, 0, 0, 0);
        drain_list();
        write_regs(12'd4095, 12'd4095);
        add_rect(0, 0, 32767, 32767);
        // shrink the clip while an entry is stored
        write_regs(12'd1, 12'd1);
        add_rect(-5, -5, 10, 10);
        drain_list();
        write_regs(12'd0, 12'd342);
        add_rect(0, 0, 10, 10);
        drain_list();

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            if (r < 2)
                write_regs($urandom_range(0, 1) ? 12'd1 : 12'd4095,
                           $urandom_range(0, 1) ? 12'd1 : 12'd4095);
            else if (r < 4)
                write_regs(drc_pkg::SCREEN_WIDTH_RST, drc_pkg::VISIBLE_HEIGHT_RST);
            else if (r < 8)
                write_regs(12'($urandom_range(16, 400)), 12'($urandom_range(16, 400)));
            tx_free = ($urandom_range(0, 3) == 0);
            rx_free = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    send_req(REQ_UNUSED, $urandom(), $urandom(), $urandom(), $urandom());
                end else if (r < 8) begin
                    send_req(drc_pkg::REQ_CLEAR, $urandom(), $urandom(), $urandom(),
                             $urandom());
                end else begin
                    random_rect(x, y, w, h);
                    add_rect(x, y, w, h);
                end
            end
            if ($urandom_range(0, 9) == 0)
                send_req(drc_pkg::REQ_CLEAR, 0, 0, 0, 0);
            else
                drain_list();
            // now and then the sender holds off until the drain has fully come out
            if ($urandom_range(0, 4) == 0) wait_idle();
        end

        wait_idle();
        rx_free = 1'b1;
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
